// ===== rtl/bve_pkg.sv =====
// shared types and constants for the bounded vector engine
package bve_pkg;

    localparam int DEPTH_DEF        = 256;
    localparam int ELEMENT_BITS_DEF = 32;
    localparam int POS_BITS         = 8;
    localparam int VALUE_BITS       = 32;
    localparam int LEN_BITS         = 9;
    localparam int REQ_BITS         = 3;
    localparam int STATUS_BITS      = 2;

    typedef enum logic [REQ_BITS-1:0] {
        REQ_APPEND = 3'd0,
        REQ_READ   = 3'd1,
        REQ_WRITE  = 3'd2,
        REQ_REMOVE = 3'd3,
        REQ_EXISTS = 3'd4
    } req_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_SUCCESS      = 2'd0,
        ST_OUT_OF_BOUND = 2'd1,
        ST_FULL         = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FIN
    } state_t;

    typedef struct packed {
        logic clear;
        logic scan;
        logic append;
        logic write;
        logic remove;
        logic read;
        logic exists;
    } cell_ctl_t;

endpackage

// ===== rtl/bve_cell.sv =====
// one element cell of the vector row with its slice of the scan chain
module bve_cell #(
    parameter int ELEMENT_BITS = bve_pkg::ELEMENT_BITS_DEF,
    parameter int IDX_BITS     = 9,
    parameter int INDEX        = 0
) (
    input  logic                    clk,
    input  bve_pkg::cell_ctl_t      ctl,
    input  logic [IDX_BITS-1:0]     pos,
    input  logic [IDX_BITS-1:0]     used,
    input  logic [ELEMENT_BITS-1:0] value,
    input  logic [ELEMENT_BITS-1:0] mask,
    input  logic [ELEMENT_BITS-1:0] nbr_elem,
    input  logic                    nbr_hit,
    input  logic [ELEMENT_BITS-1:0] nbr_data,
    output logic [ELEMENT_BITS-1:0] elem,
    output logic                    hit,
    output logic [ELEMENT_BITS-1:0] data
);

    localparam logic [IDX_BITS-1:0] IDX      = IDX_BITS'(INDEX);
    localparam logic [IDX_BITS-1:0] NEXT_IDX = IDX_BITS'(INDEX + 1);

    logic [ELEMENT_BITS-1:0] elem_reg;
    logic [ELEMENT_BITS-1:0] elem_next;
    logic                    hit_reg;
    logic                    hit_next;
    logic [ELEMENT_BITS-1:0] data_reg;
    logic [ELEMENT_BITS-1:0] data_next;
    logic                    at_pos;
    logic                    at_end;
    logic                    below_used;
    logic                    shift_ok;
    logic                    match;

    always_comb
    begin
        at_pos     = (IDX == pos);
        at_end     = (IDX == used);
        below_used = (IDX < used);
        shift_ok   = (IDX >= pos) && (NEXT_IDX < used);
        match      = below_used && (((elem_reg ^ value) & mask) == '0);

        priority if (ctl.append && at_end)
        begin
            elem_next = value;
        end
        else if (ctl.write && at_pos)
        begin
            elem_next = value;
        end
        else if (ctl.remove && shift_ok)
        begin
            elem_next = nbr_elem;
        end
        else
        begin
            elem_next = elem_reg;
        end

        priority if (ctl.clear)
        begin
            hit_next  = 1'b0;
            data_next = '0;
        end
        else if (ctl.scan)
        begin
            hit_next  = nbr_hit | (ctl.exists & match);
            data_next = nbr_data | ((ctl.read && at_pos) ? elem_reg : '0);
        end
        else
        begin
            hit_next  = hit_reg;
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        elem_reg <= elem_next;
        hit_reg  <= hit_next;
        data_reg <= data_next;
    end

    assign elem = elem_reg;
    assign hit  = hit_reg;
    assign data = data_reg;

endmodule

// ===== rtl/bounded_vector_engine.sv =====
// bounded vector engine: request sequencer over a row of element cells
// append, write, remove, refused and unknown requests run through S_EXEC, which registers done
// read in range and exists walk the scan chain in S_SCAN, then S_FIN registers done
// a new item is taken in the done cycle at the earliest; start is ignored while busy
// reset: length 0, compare_mask all ones, element contents undefined until written
// results cannot be stalled; done is a one-cycle strobe
module bounded_vector_engine #(
    parameter int DEPTH        = bve_pkg::DEPTH_DEF,
    parameter int ELEMENT_BITS = bve_pkg::ELEMENT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [bve_pkg::REQ_BITS-1:0]    req_type,
    input  logic [bve_pkg::POS_BITS-1:0]    position,
    input  logic [bve_pkg::VALUE_BITS-1:0]  element_value,
    output logic                            done,
    output logic [bve_pkg::STATUS_BITS-1:0] status,
    output logic [bve_pkg::VALUE_BITS-1:0]  read_value,
    output logic                            found,
    output logic [bve_pkg::LEN_BITS-1:0]    length,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bve_pkg::VALUE_BITS-1:0]  cfg_data
);

    localparam int IDX_BITS = $clog2(DEPTH + 1);
    localparam int CNT_BITS = $clog2(DEPTH);
    localparam int PB       = bve_pkg::POS_BITS;
    localparam int VB       = bve_pkg::VALUE_BITS;
    localparam int LB       = bve_pkg::LEN_BITS;

    bve_pkg::state_t            state_reg;
    bve_pkg::state_t            state_next;
    bve_pkg::req_t              req_reg;
    bve_pkg::req_t              req_next;
    logic [PB-1:0]              pos_reg;
    logic [PB-1:0]              pos_next;
    logic [ELEMENT_BITS-1:0]    val_reg;
    logic [ELEMENT_BITS-1:0]    val_next;
    logic [CNT_BITS-1:0]        cnt_reg;
    logic [CNT_BITS-1:0]        cnt_next;
    logic [IDX_BITS-1:0]        used_reg;
    logic [IDX_BITS-1:0]        used_next;
    logic [VB-1:0]              mask_reg;
    logic [VB-1:0]              mask_next;
    logic                       done_reg;
    logic                       done_next;
    bve_pkg::status_t           status_reg;
    bve_pkg::status_t           status_next;
    logic [VB-1:0]              read_value_reg;
    logic [VB-1:0]              read_value_next;
    logic                       found_reg;
    logic                       found_next;

    bve_pkg::cell_ctl_t         ctl;
    logic                       accept;
    logic [ELEMENT_BITS+VB-1:0] val_wide;
    logic [ELEMENT_BITS+VB-1:0] mask_wide;
    logic [VB+ELEMENT_BITS-1:0] rd_wide;
    logic [IDX_BITS+PB-1:0]     pos_in_wide;
    logic [IDX_BITS+PB-1:0]     pos_reg_wide;
    logic [PB+IDX_BITS-1:0]     used_wide;
    logic [IDX_BITS+LB-1:0]     len_wide;
    logic                       oob_in;
    logic                       oob;
    logic                       full;

    logic [ELEMENT_BITS-1:0]    elem_w [DEPTH+1];
    logic                       hit_w  [DEPTH+1];
    logic [ELEMENT_BITS-1:0]    data_w [DEPTH+1];

    assign elem_w[DEPTH] = '0;
    assign hit_w[DEPTH]  = 1'b0;
    assign data_w[DEPTH] = '0;

    assign accept       = start && (state_reg == bve_pkg::S_IDLE);
    assign busy         = (state_reg != bve_pkg::S_IDLE);
    assign cfg_ready    = 1'b1;
    assign val_wide     = {{ELEMENT_BITS{1'b0}}, element_value};
    assign mask_wide    = {{ELEMENT_BITS{1'b0}}, mask_reg};
    assign rd_wide      = {{VB{1'b0}}, data_w[0]};
    assign pos_in_wide  = {{IDX_BITS{1'b0}}, position};
    assign pos_reg_wide = {{IDX_BITS{1'b0}}, pos_reg};
    assign used_wide    = {{PB{1'b0}}, used_reg};
    assign len_wide     = {{LB{1'b0}}, used_reg};
    assign oob_in       = (pos_in_wide >= used_wide);
    assign oob          = (pos_reg_wide >= used_wide);
    assign full         = (used_reg == IDX_BITS'(DEPTH));

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            bve_cell #(
                .ELEMENT_BITS (ELEMENT_BITS),
                .IDX_BITS     (IDX_BITS),
                .INDEX        (gi)
            ) u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .pos      (pos_reg_wide[IDX_BITS-1:0]),
                .used     (used_reg),
                .value    (val_reg),
                .mask     (mask_wide[ELEMENT_BITS-1:0]),
                .nbr_elem (elem_w[gi+1]),
                .nbr_hit  (hit_w[gi+1]),
                .nbr_data (data_w[gi+1]),
                .elem     (elem_w[gi]),
                .hit      (hit_w[gi]),
                .data     (data_w[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bve_pkg::S_IDLE;
            cnt_reg   <= '0;
            used_reg  <= '0;
            mask_reg  <= '1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            used_reg  <= used_next;
            mask_reg  <= mask_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        status_reg     <= status_next;
        read_value_reg <= read_value_next;
        found_reg      <= found_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        cnt_next        = cnt_reg;
        used_next       = used_reg;
        mask_next       = (cfg_valid && cfg_ready) ? cfg_data : mask_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        read_value_next = read_value_reg;
        found_next      = found_reg;
        ctl             = '0;

        unique case (state_reg)
            bve_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    req_next   = bve_pkg::req_t'(req_type);
                    pos_next   = position;
                    val_next   = val_wide[ELEMENT_BITS-1:0];
                    cnt_next   = '0;
                    ctl.clear  = 1'b1;
                    if ((req_type == bve_pkg::REQ_EXISTS) ||
                        ((req_type == bve_pkg::REQ_READ) && !oob_in))
                    begin
                        state_next = bve_pkg::S_SCAN;
                    end
                    else
                    begin
                        state_next = bve_pkg::S_EXEC;
                    end
                end
            end
            bve_pkg::S_EXEC:
            begin
                status_next     = bve_pkg::ST_SUCCESS;
                read_value_next = '0;
                found_next      = 1'b0;
                unique case (req_reg)
                    bve_pkg::REQ_APPEND:
                    begin
                        if (full)
                        begin
                            status_next = bve_pkg::ST_FULL;
                        end
                        else
                        begin
                            ctl.append = 1'b1;
                            used_next  = used_reg + 1'b1;
                        end
                    end
                    bve_pkg::REQ_READ:
                    begin
                        if (oob)
                        begin
                            status_next = bve_pkg::ST_OUT_OF_BOUND;
                        end
                    end
                    bve_pkg::REQ_WRITE:
                    begin
                        if (oob)
                        begin
                            status_next = bve_pkg::ST_OUT_OF_BOUND;
                        end
                        else
                        begin
                            ctl.write = 1'b1;
                        end
                    end
                    bve_pkg::REQ_REMOVE:
                    begin
                        if (oob)
                        begin
                            status_next = bve_pkg::ST_OUT_OF_BOUND;
                        end
                        else
                        begin
                            ctl.remove = 1'b1;
                            used_next  = used_reg - 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                done_next  = 1'b1;
                state_next = bve_pkg::S_IDLE;
            end
            bve_pkg::S_SCAN:
            begin
                ctl.scan   = 1'b1;
                ctl.read   = (req_reg == bve_pkg::REQ_READ);
                ctl.exists = (req_reg == bve_pkg::REQ_EXISTS);
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(DEPTH - 1))
                begin
                    state_next = bve_pkg::S_FIN;
                end
            end
            bve_pkg::S_FIN:
            begin
                status_next     = bve_pkg::ST_SUCCESS;
                read_value_next = (req_reg == bve_pkg::REQ_READ) ? rd_wide[VB-1:0] : '0;
                found_next      = (req_reg == bve_pkg::REQ_EXISTS) && hit_w[0];
                done_next       = 1'b1;
                state_next      = bve_pkg::S_IDLE;
            end
            default:
            begin
                state_next = bve_pkg::S_IDLE;
            end
        endcase
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign read_value = read_value_reg;
    assign found      = found_reg;
    assign length     = len_wide[LB-1:0];

`ifndef SYNTH
    a_used_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= IDX_BITS'(DEPTH))
        else $error("element count beyond capacity");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == bve_pkg::S_EXEC) ||
                 ($past(state_reg) == bve_pkg::S_FIN))
        else $error("done without a finished item");

    a_len_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != $past(used_reg)) |-> done)
        else $error("length changed outside an item completion");

    a_found_only_success: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> (status == bve_pkg::ST_SUCCESS))
        else $error("found with a failing status");
`endif

endmodule
